[sv/tqps_pkg.sv]
// Shared types, register indexes and constants for the textured quad pixel shader.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tqps_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CFG_ORIGIN   = 3'd0;
   localparam logic [2:0] CFG_X_AXIS   = 3'd1;
   localparam logic [2:0] CFG_Y_AXIS   = 3'd2;
   localparam logic [2:0] CFG_INV_X    = 3'd3;
   localparam logic [2:0] CFG_INV_Y    = 3'd4;
   localparam logic [2:0] CFG_TEX_W    = 3'd5;
   localparam logic [2:0] CFG_TEX_H    = 3'd6;

   // Operation codes of an input word.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SHADE = 1'b1;

   // Parameter defaults.
   localparam int TEX_DEPTH_DEF  = 65536;
   localparam int COORD_BITS_DEF = 12;

   // Width of a linear texel address before it wraps to the store depth.
   localparam int ADDR_VW = 17;

   // Colors and blend constants.
   localparam logic [31:0] MAGENTA      = 32'hFF00FFFF;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [23:0] BLEND_DEN    = 24'd16711680;  // 255 * 65536
   localparam logic [23:0] BLEND_HALF   = 24'd8355840;   // half of the denominator
   localparam logic [17:0] BLEND_SAT    = 18'd65280;     // 256 * 255
   localparam logic [15:0] RECIP_255    = 16'h8081;      // 2^23 / 255, rounded up

   // Four neighboring texels of one bilinear sample.
   typedef struct packed {
      logic [31:0] ta;
      logic [31:0] tb;
      logic [31:0] tc;
      logic [31:0] td;
   } quad_type;

   // Everything the blend pipeline needs for one pixel.
   typedef struct packed {
      quad_type    texels;
      logic [7:0]  wx;
      logic [7:0]  wy;
      logic [31:0] dest;
      logic        in_quad;
   } samp_type;

   // Per-stage bookkeeping that travels along the main pipeline.
   typedef struct packed {
      logic        valid;
      logic        op;
      logic        in_quad;
      logic [11:0] x;
      logic [11:0] y;
      logic [31:0] dest;
      logic [15:0] idx;
      logic [31:0] tval;
      logic [7:0]  wx;
      logic [7:0]  wy;
   } meta_type;

endpackage
`default_nettype wire

[sv/tqps_addr_wrap.sv]
// Two-stage wrap of a linear texel address modulo the texture store depth.
// Depends on tqps_pkg for the linear address width.
`default_nettype none
module tqps_addr_wrap
   import tqps_pkg::*;
#(
   parameter int TEX_DEPTH = TEX_DEPTH_DEF,
   parameter int AW        = $clog2(TEX_DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [ADDR_VW-1:0] lin_addr,
   output logic      [AW-1:0]      addr_ff
);

   localparam int RECIP = (1 << ADDR_VW) / TEX_DEPTH;
   localparam int PW    = ADDR_VW + 21;

   logic [ADDR_VW-1:0] lin_ff, lin_in;
   logic [ADDR_VW-1:0] quo_ff, quo_in;
   logic [PW-1:0]      prod, rem_full;
   logic [ADDR_VW-1:0] rem;
   logic [AW-1:0]      addr_in;

   // First stage: quotient estimate by reciprocal, low by at most one.
   always_comb begin
      lin_in = lin_addr;
      quo_in = ADDR_VW'(((2 * ADDR_VW)'(lin_addr) * (2 * ADDR_VW)'(RECIP)) >> ADDR_VW);
   end

   // Second stage: remainder with one correcting subtraction.
   always_comb begin
      prod     = PW'(quo_ff) * PW'(TEX_DEPTH);
      rem_full = PW'(lin_ff) - prod;
      rem      = rem_full[ADDR_VW-1:0];
      if (PW'(rem) >= PW'(TEX_DEPTH)) begin
         rem = ADDR_VW'(PW'(rem) - PW'(TEX_DEPTH));
      end
      addr_in = AW'(rem);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff  <= lin_in;
         quo_ff  <= quo_in;
         addr_ff <= addr_in;
      end
   end

endmodule
`default_nettype wire

[sv/tqps_tex_store.sv]
// Texture store: two mirrored synchronous memories, each with two read ports.
// Depends on tqps_pkg for the texel quad type.
`default_nettype none
module tqps_tex_store
   import tqps_pkg::*;
#(
   parameter int TEX_DEPTH = TEX_DEPTH_DEF,
   parameter int AW        = $clog2(TEX_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [31:0]   wdata,
   input  wire logic [AW-1:0] raddr_a,
   input  wire logic [AW-1:0] raddr_b,
   input  wire logic [AW-1:0] raddr_c,
   input  wire logic [AW-1:0] raddr_d,
   output quad_type           texels_ff
);

   logic [31:0] upper_mem [0:TEX_DEPTH-1];
   logic [31:0] lower_mem [0:TEX_DEPTH-1];

   // A load word writes both copies so that four texels can be read each cycle in which en is high.
   always_ff @(posedge clock) begin
      if (we) begin
         upper_mem[waddr] <= wdata;
         lower_mem[waddr] <= wdata;
      end
   end

   // The upper copy serves the top texel pair, the lower copy the bottom pair.
   always_ff @(posedge clock) begin
      if (en) begin
         texels_ff.ta <= upper_mem[raddr_a];
         texels_ff.tb <= upper_mem[raddr_b];
         texels_ff.tc <= lower_mem[raddr_c];
         texels_ff.td <= lower_mem[raddr_d];
      end
   end

endmodule
`default_nettype wire

[sv/tqps_blend.sv]
// Bilinear filter and premultiplied-alpha blend, four pipeline stages.
// Depends on tqps_pkg for the sample type and blend constants.
`default_nettype none
module tqps_blend
   import tqps_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     en,
   input  wire samp_type samp,
   output logic [31:0]   color_ff
);

   logic [16:0] ab_ff [4];
   logic [16:0] ab_in [4];
   logic [16:0] cd_ff [4];
   logic [16:0] cd_in [4];
   logic [23:0] s_ff  [4];
   logic [23:0] s_in  [4];
   logic [33:0] num_ff [3];
   logic [33:0] num_in [3];
   logic [7:0]  wy_ff;
   logic [31:0] dest1_ff, dest2_ff;
   logic        inside1_ff, inside2_ff, inside3_ff;
   logic [31:0] color_in;

   // Horizontal lerps of the top and bottom texel pairs.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ab_in[k] = 17'(samp.texels.ta[24 - 8 * k +: 8]) * (17'd256 - 17'(samp.wx))
                  + 17'(samp.texels.tb[24 - 8 * k +: 8]) * 17'(samp.wx);
         cd_in[k] = 17'(samp.texels.tc[24 - 8 * k +: 8]) * (17'd256 - 17'(samp.wx))
                  + 17'(samp.texels.td[24 - 8 * k +: 8]) * 17'(samp.wx);
      end
   end

   // Vertical lerp; each sample channel is Q8.16.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s_in[k] = 24'(26'(ab_ff[k]) * (26'd256 - 26'(wy_ff))
                     + 26'(cd_ff[k]) * 26'(wy_ff));
      end
   end

   // Blend numerator per color channel: D * (den - Sa) + S * 255.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = 34'(dest2_ff[24 - 8 * k +: 8]) * 34'(BLEND_DEN - s_ff[3])
                   + 34'(s_ff[k]) * 34'd255;
      end
   end

   // Rounded division by the denominator, with saturation at 255.
   always_comb begin
      logic [17:0] t;
      logic [7:0]  r [3];
      for (int k = 0; k < 3; k++) begin
         t = 18'((num_ff[k] + 34'(BLEND_HALF)) >> 16);
         if (t >= BLEND_SAT) begin
            r[k] = 8'hFF;
         end else begin
            r[k] = 8'((32'(t[15:0]) * 32'(RECIP_255)) >> 23);
         end
      end
      color_in = inside3_ff ? {r[0], r[1], r[2], ALPHA_OPAQUE} : MAGENTA;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ab_ff      <= ab_in;
         cd_ff      <= cd_in;
         wy_ff      <= samp.wy;
         dest1_ff   <= samp.dest;
         inside1_ff <= samp.in_quad;
         s_ff       <= s_in;
         dest2_ff   <= dest1_ff;
         inside2_ff <= inside1_ff;
         num_ff     <= num_in;
         inside3_ff <= inside2_ff;
         color_ff   <= color_in;
      end
   end

endmodule
`default_nettype wire

[sv/textured_quad_pixel_shader_unit.sv]
// Top level of the textured quad pixel shader: edge tests, UV mapping, texel
// addressing and result handshake. Depends on tqps_pkg, tqps_addr_wrap,
// tqps_tex_store and tqps_blend.
//
//   channel   ports                              direction
//   req       req_valid/req_ready + 6 fields     in
//   rsp       rsp_valid/rsp_ready + 4 fields     out
//   csr       csr_we, csr_index, csr_wdata       in (write only)
//
// One word enters per cycle while the pipeline is not stalled; a shade word
// leaves from the last stage. A load word writes the texture store in the same
// stage in which later shade words read it, so no forwarding is needed.
// The whole pipeline advances together and stalls while a result waits.
// Reset clears the quad configuration and the stage valid bits and sets the
// texture size to 256 by 256; texture contents are undefined until loaded.
`default_nettype none
module textured_quad_pixel_shader_unit
   import tqps_pkg::*;
#(
   parameter int TEX_DEPTH  = TEX_DEPTH_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [15:0] req_texel_index,
   input  wire logic [31:0] req_texel_value,
   input  wire logic [11:0] req_pixel_x,
   input  wire logic [11:0] req_pixel_y,
   input  wire logic [31:0] req_dest_pixel,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_out_x,
   output logic [11:0]      rsp_out_y,
   output logic [31:0]      rsp_out_color,
   output logic             rsp_inside_res,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int AW  = $clog2(TEX_DEPTH);
   localparam int XB  = (COORD_BITS < 12) ? COORD_BITS : 12;
   localparam int PW  = (((XB + 4) > 16) ? (XB + 4) : 16) + 2;
   localparam int DW  = PW + 2;
   localparam int PRW = DW + 16;
   localparam int NST = 15;

   // Configuration registers.
   logic [31:0] origin_ff, x_axis_ff, y_axis_ff, inv_x_ff, inv_y_ff;
   logic [8:0]  tex_w_ff, tex_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         x_axis_ff <= '0;
         y_axis_ff <= '0;
         inv_x_ff  <= '0;
         inv_y_ff  <= '0;
         tex_w_ff  <= 9'd256;
         tex_h_ff  <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            CFG_ORIGIN: origin_ff <= csr_wdata;
            CFG_X_AXIS: x_axis_ff <= csr_wdata;
            CFG_Y_AXIS: y_axis_ff <= csr_wdata;
            CFG_INV_X:  inv_x_ff  <= csr_wdata;
            CFG_INV_Y:  inv_y_ff  <= csr_wdata;
            CFG_TEX_W:  tex_w_ff  <= csr_wdata[8:0];
            CFG_TEX_H:  tex_h_ff  <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   // Unpacked quad geometry and clamped texture size.
   logic signed [15:0] ox, oy, xx, xy, yx, yy;
   logic [8:0]         tw, th;

   always_comb begin
      ox = $signed(origin_ff[31:16]);
      oy = $signed(origin_ff[15:0]);
      xx = $signed(x_axis_ff[31:16]);
      xy = $signed(x_axis_ff[15:0]);
      yx = $signed(y_axis_ff[31:16]);
      yy = $signed(y_axis_ff[15:0]);
      tw = (tex_w_ff < 9'd2) ? 9'd2 : ((tex_w_ff > 9'd256) ? 9'd256 : tex_w_ff);
      th = (tex_h_ff < 9'd2) ? 9'd2 : ((tex_h_ff > 9'd256) ? 9'd256 : tex_h_ff);
   end

   // Pipeline advance: everything moves unless a finished result is held.
   logic en;
   meta_type meta_ff [1:NST];
   meta_type meta_in [1:NST];

   assign rsp_valid = meta_ff[NST].valid && (meta_ff[NST].op == OP_SHADE);
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Stage 1: pixel position relative to the origin, Q.4.
   logic signed [PW-1:0] px_ff, py_ff, px_in, py_in;

   always_comb begin
      px_in = $signed(PW'({req_pixel_x[XB-1:0], 4'b0000})) - PW'(ox);
      py_in = $signed(PW'({req_pixel_y[XB-1:0], 4'b0000})) - PW'(oy);
   end

   // Stage 2: offsets from each quad corner.
   logic signed [DW-1:0] dx_ff [4];
   logic signed [DW-1:0] dy_ff [4];
   logic signed [DW-1:0] dx_in [4];
   logic signed [DW-1:0] dy_in [4];

   always_comb begin
      dx_in[0] = DW'(px_ff);
      dy_in[0] = DW'(py_ff);
      dx_in[1] = DW'(px_ff) - DW'(xx);
      dy_in[1] = DW'(py_ff) - DW'(xy);
      dx_in[2] = DW'(px_ff) - DW'(xx) - DW'(yx);
      dy_in[2] = DW'(py_ff) - DW'(xy) - DW'(yy);
      dx_in[3] = DW'(px_ff) - DW'(yx);
      dy_in[3] = DW'(py_ff) - DW'(yy);
   end

   // Stage 3: cross and dot products, each edge value is pos minus neg.
   logic signed [PRW-1:0] epos_ff [4];
   logic signed [PRW-1:0] eneg_ff [4];
   logic signed [PRW-1:0] epos_in [4];
   logic signed [PRW-1:0] eneg_in [4];
   logic signed [PRW-1:0] dot_ff  [4];
   logic signed [PRW-1:0] dot_in  [4];

   always_comb begin
      epos_in[0] = PRW'(dy_ff[0]) * PRW'(xx);
      eneg_in[0] = PRW'(dx_ff[0]) * PRW'(xy);
      epos_in[1] = PRW'(dy_ff[1]) * PRW'(yx);
      eneg_in[1] = PRW'(dx_ff[1]) * PRW'(yy);
      epos_in[2] = PRW'(dx_ff[2]) * PRW'(xy);
      eneg_in[2] = PRW'(dy_ff[2]) * PRW'(xx);
      epos_in[3] = PRW'(dx_ff[3]) * PRW'(yy);
      eneg_in[3] = PRW'(dy_ff[3]) * PRW'(yx);
      dot_in[0]  = PRW'(dx_ff[0]) * PRW'(xx);
      dot_in[1]  = PRW'(dy_ff[0]) * PRW'(xy);
      dot_in[2]  = PRW'(dx_ff[0]) * PRW'(yx);
      dot_in[3]  = PRW'(dy_ff[0]) * PRW'(yy);
   end

   // Stage 4: strict edge tests and the two axis projections.
   logic signed [PRW:0] du_ff, dv_ff, du_in, dv_in;
   logic                inside_in;

   always_comb begin
      logic signed [PRW:0] e;
      inside_in = 1'b1;
      for (int k = 0; k < 4; k++) begin
         e = (PRW + 1)'(epos_ff[k]) - (PRW + 1)'(eneg_ff[k]);
         if (e <= 0) begin
            inside_in = 1'b0;
         end
      end
      du_in = (PRW + 1)'(dot_ff[0]) + (PRW + 1)'(dot_ff[1]);
      dv_in = (PRW + 1)'(dot_ff[2]) + (PRW + 1)'(dot_ff[3]);
   end

   // Stage 5: projection times reciprocal length, split in 16-bit halves.
   logic [PRW+15:0] ua_ff, ub_ff, va_ff, vb_ff;
   logic [PRW+15:0] ua_in, ub_in, va_in, vb_in;

   always_comb begin
      logic [PRW-1:0] du_pos, dv_pos;
      du_pos = (du_ff > 0) ? du_ff[PRW-1:0] : '0;
      dv_pos = (dv_ff > 0) ? dv_ff[PRW-1:0] : '0;
      ua_in  = (PRW + 16)'(du_pos) * (PRW + 16)'(inv_x_ff[31:16]);
      ub_in  = (PRW + 16)'(du_pos) * (PRW + 16)'(inv_x_ff[15:0]);
      va_in  = (PRW + 16)'(dv_pos) * (PRW + 16)'(inv_y_ff[31:16]);
      vb_in  = (PRW + 16)'(dv_pos) * (PRW + 16)'(inv_y_ff[15:0]);
   end

   // Stage 6: U and V in Q1.16, limited to one.
   logic [16:0] u_ff, v_ff, u_in, v_in;

   always_comb begin
      logic [PRW+16:0] su, sv;
      su   = ((PRW + 17)'(ua_ff) + (PRW + 17)'(ub_ff >> 16)) >> 8;
      sv   = ((PRW + 17)'(va_ff) + (PRW + 17)'(vb_ff >> 16)) >> 8;
      u_in = (su > (PRW + 17)'(65536)) ? 17'd65536 : su[16:0];
      v_in = (sv > (PRW + 17)'(65536)) ? 17'd65536 : sv[16:0];
   end

   // Stage 7: texel positions in Q.16.
   logic [24:0] fx_ff, fy_ff, fx_in, fy_in;

   always_comb begin
      fx_in = 25'(u_ff) * 25'(tw - 9'd2);
      fy_in = 25'(v_ff) * 25'(th - 9'd2);
   end

   // Stage 8: linear address of the top-left texel.
   logic [ADDR_VW-1:0] base_ff, base_in;

   always_comb begin
      base_in = ADDR_VW'(tw) * ADDR_VW'(fy_ff[23:16]) + ADDR_VW'(fx_ff[23:16]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         epos_ff <= epos_in;
         eneg_ff <= eneg_in;
         dot_ff  <= dot_in;
         du_ff   <= du_in;
         dv_ff   <= dv_in;
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         va_ff   <= va_in;
         vb_ff   <= vb_in;
         u_ff    <= u_in;
         v_ff    <= v_in;
         fx_ff   <= fx_in;
         fy_ff   <= fy_in;
         base_ff <= base_in;
      end
   end

   // Word bookkeeping along the pipeline; the edge test and the weights join it.
   always_comb begin
      meta_in[1].valid   = req_valid;
      meta_in[1].op      = req_op;
      meta_in[1].in_quad = 1'b0;
      meta_in[1].x       = req_pixel_x;
      meta_in[1].y       = req_pixel_y;
      meta_in[1].dest    = req_dest_pixel;
      meta_in[1].idx     = req_texel_index;
      meta_in[1].tval    = req_texel_value;
      meta_in[1].wx      = '0;
      meta_in[1].wy      = '0;
      for (int k = 2; k <= NST; k++) begin
         meta_in[k] = meta_ff[k-1];
      end
      meta_in[4].in_quad = inside_in;
      meta_in[8].wx      = fx_ff[15:8];
      meta_in[8].wy      = fy_ff[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NST; k++) begin
            meta_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         for (int k = 1; k <= NST; k++) begin
            meta_ff[k] <= meta_in[k];
         end
      end
   end

   // Stages 9 and 10: wrap the four texel addresses, or the load address.
   logic [ADDR_VW-1:0] lin [4];
   logic [AW-1:0]      addr [4];

   always_comb begin
      lin[0] = (meta_ff[8].op == OP_LOAD) ? ADDR_VW'(meta_ff[8].idx) : base_ff;
      lin[1] = base_ff + ADDR_VW'(1);
      lin[2] = base_ff + ADDR_VW'(tw);
      lin[3] = base_ff + ADDR_VW'(tw) + ADDR_VW'(1);
   end

   for (genvar g = 0; g < 4; g++) begin : g_wrap
      tqps_addr_wrap #(
         .TEX_DEPTH(TEX_DEPTH),
         .AW       (AW)
      ) u_wrap (
         .clock   (clock),
         .en      (en),
         .lin_addr(lin[g]),
         .addr_ff (addr[g])
      );
   end

   // Stage 11: texture store write for loads, four texel reads for shades.
   quad_type texels;
   logic     store_we;

   assign store_we = en && meta_ff[10].valid && (meta_ff[10].op == OP_LOAD);

   tqps_tex_store #(
      .TEX_DEPTH(TEX_DEPTH),
      .AW       (AW)
   ) u_store (
      .clock    (clock),
      .en       (en),
      .we       (store_we),
      .waddr    (addr[0]),
      .wdata    (meta_ff[10].tval),
      .raddr_a  (addr[0]),
      .raddr_b  (addr[1]),
      .raddr_c  (addr[2]),
      .raddr_d  (addr[3]),
      .texels_ff(texels)
   );

   // Stages 12 to 15: filter and blend.
   samp_type samp;

   always_comb begin
      samp.texels  = texels;
      samp.wx      = meta_ff[11].wx;
      samp.wy      = meta_ff[11].wy;
      samp.dest    = meta_ff[11].dest;
      samp.in_quad = meta_ff[11].in_quad;
   end

   tqps_blend u_blend (
      .clock   (clock),
      .en      (en),
      .samp    (samp),
      .color_ff(rsp_out_color)
   );

   // Result word.
   assign rsp_out_x      = meta_ff[NST].x;
   assign rsp_out_y      = meta_ff[NST].y;
   assign rsp_inside_res = meta_ff[NST].in_quad;

endmodule
`default_nettype wire
